/* rtl/iat_pkg.sv */
// ----------------------------------------------------------------------------
// Interval time averager package
// Widths, reset values and register indexes shared by the averager RTL.
// ----------------------------------------------------------------------------
package iat_pkg;

  localparam int ELAPSED_W          = 16;
  localparam int TOTAL_W            = 32;
  localparam int AVG_W              = 40;
  localparam int CFG_DATA_W         = 32;
  localparam int CFG_INDEX_W        = 1;
  localparam int FRACTION_BITS_DEF  = 8;

  localparam logic [TOTAL_W-1:0] INTERVAL_RESET = TOTAL_W'(1000);
  localparam logic [AVG_W-1:0]   AVG_MAX        = '1;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_MODE    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL_VALUE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

endpackage

/* rtl/interval_time_averager_top.sv */
// ----------------------------------------------------------------------------
// Interval time averager
// Accumulates elapsed time per update and latches the window average.
// ----------------------------------------------------------------------------
// Each input word is one update carrying the time since the previous update.
// The word is added to a saturating 32-bit total and counted in the cycle it
// is accepted. The next cycle checks whether the window closes. A word that
// does not close a window goes straight to the done state, which writes its
// result word to the output register once the output is free. The block then
// returns to idle and takes the next word. A word that closes a window runs a
// restoring bit-serial divider, one quotient bit per cycle, over the total
// shifted up by FRACTION_BITS fraction bits, dividing it by the update count;
// the done state then writes the clamped quotient as the new average once the
// output is free. A stalled result word holds the block in the done state.
// One word is worked on at a time. in_stall is low only while the block is
// idle and no register is being written. Every input word yields exactly one
// result word, which carries the latest average.
module interval_time_averager_top #(
  parameter int FRACTION_BITS = iat_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [iat_pkg::ELAPSED_W-1:0]    in_elapsed_ticks,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [iat_pkg::AVG_W-1:0]        out_average_time,
  output logic                             out_window_closed,
  input  logic                             cfg_wr_en,
  input  logic [iat_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [iat_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int TW = iat_pkg::TOTAL_W;
  localparam int AW = iat_pkg::AVG_W;
  localparam int NW = TW + FRACTION_BITS;
  localparam int QW = (NW > AW) ? NW : AW;
  localparam int CW = $clog2(NW);

  iat_pkg::state_t state_r, state_nxt;

  logic          mode_r, mode_nxt;
  logic [TW-1:0] interval_r, interval_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [TW-1:0] count_r, count_nxt;
  logic [AW-1:0] avg_r, avg_nxt;
  logic          closed_r, closed_nxt;
  logic [NW-1:0] quot_r, quot_nxt;
  logic [TW-1:0] rem_r, rem_nxt;
  logic [TW-1:0] div_r, div_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [AW-1:0] out_avg_r, out_avg_nxt;
  logic          out_closed_r, out_closed_nxt;

  logic          in_accept;
  logic [TW:0]   sum;
  logic          time_ok;
  logic          count_ok;
  logic          close;
  logic [TW:0]   trial;
  logic [TW:0]   diff;
  logic          trial_ge;
  logic [QW-1:0] quot_ext;
  logic          out_free;

  assign in_stall  = (state_r != iat_pkg::ST_IDLE) || cfg_wr_en;
  assign in_accept = in_valid && !in_stall;

  assign sum      = {1'b0, total_r} + (TW + 1)'(in_elapsed_ticks);
  assign time_ok  = (total_r >= interval_r);
  assign count_ok = (count_r > interval_r);
  assign close    = mode_r ? (count_ok && time_ok) : time_ok;

  assign trial    = {rem_r, quot_r[NW-1]};
  assign diff     = trial - {1'b0, div_r};
  assign trial_ge = (trial >= {1'b0, div_r});
  assign quot_ext = QW'(quot_r);

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    interval_nxt   = interval_r;
    total_nxt      = total_r;
    count_nxt      = count_r;
    avg_nxt        = avg_r;
    closed_nxt     = closed_r;
    quot_nxt       = quot_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_avg_nxt    = out_avg_r;
    out_closed_nxt = out_closed_r;

    case (state_r)
      iat_pkg::ST_IDLE: begin
        if (cfg_wr_en) begin
          case (cfg_index)
            iat_pkg::REG_WINDOW_MODE: begin
              mode_nxt  = cfg_wdata[0];
              total_nxt = '0;
              count_nxt = '0;
              avg_nxt   = '0;
            end
            iat_pkg::REG_INTERVAL_VALUE: begin
              interval_nxt = cfg_wdata[TW-1:0];
              total_nxt    = '0;
              count_nxt    = '0;
              avg_nxt      = '0;
            end
            default: begin
            end
          endcase
        end else if (in_accept) begin
          total_nxt = sum[TW] ? '1 : sum[TW-1:0];
          count_nxt = (&count_r) ? count_r : count_r + TW'(1);
          state_nxt = iat_pkg::ST_EVAL;
        end
      end
      iat_pkg::ST_EVAL: begin
        closed_nxt = close;
        if (close) begin
          quot_nxt  = NW'(total_r) << FRACTION_BITS;
          rem_nxt   = '0;
          div_nxt   = count_r;
          cnt_nxt   = CW'(NW - 1);
          total_nxt = '0;
          count_nxt = '0;
          state_nxt = iat_pkg::ST_DIV;
        end else begin
          state_nxt = iat_pkg::ST_DONE;
        end
      end
      iat_pkg::ST_DIV: begin
        rem_nxt  = trial_ge ? diff[TW-1:0] : trial[TW-1:0];
        quot_nxt = {quot_r[NW-2:0], trial_ge};
        cnt_nxt  = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          state_nxt = iat_pkg::ST_DONE;
        end
      end
      iat_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_closed_nxt = closed_r;
          if (closed_r) begin
            avg_nxt     = (quot_ext > QW'(iat_pkg::AVG_MAX)) ? iat_pkg::AVG_MAX
                                                             : AW'(quot_ext);
            out_avg_nxt = avg_nxt;
          end else begin
            out_avg_nxt = avg_r;
          end
          state_nxt = iat_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = iat_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iat_pkg::ST_IDLE;
      mode_r      <= 1'b0;
      interval_r  <= iat_pkg::INTERVAL_RESET;
      total_r     <= '0;
      count_r     <= '0;
      avg_r       <= '0;
      closed_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      interval_r  <= interval_nxt;
      total_r     <= total_nxt;
      count_r     <= count_nxt;
      avg_r       <= avg_nxt;
      closed_r    <= closed_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r       <= quot_nxt;
    rem_r        <= rem_nxt;
    div_r        <= div_nxt;
    out_avg_r    <= out_avg_nxt;
    out_closed_r <= out_closed_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_average_time  = out_avg_r;
  assign out_window_closed = out_closed_r;

  a_count_nonzero_eval: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == iat_pkg::ST_EVAL) |-> (count_r != '0)
  ) else $error("update count is zero when a window is evaluated");

  a_divisor_nonzero: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == iat_pkg::ST_DIV) |-> (div_r != '0)
  ) else $error("divider runs with a zero divisor");

  a_remainder_bound: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == iat_pkg::ST_DIV) |-> (rem_r < div_r)
  ) else $error("divider remainder is not below the divisor");

  a_close_clears: assert property (
    @(posedge clk) disable iff (!rst_n)
    ((state_r == iat_pkg::ST_EVAL) && close) |=> ((total_r == '0) && (count_r == '0))
  ) else $error("window close did not clear the accumulators");

  a_result_after_item: assert property (
    @(posedge clk) disable iff (!rst_n)
    ((state_r == iat_pkg::ST_DONE) && out_free) |=> out_valid_r
  ) else $error("finished word did not reach the output register");

endmodule
